// File: design/bit_vector_set_engine_core_assert.svh
// ----------------------------------------------------------------------------
// Bit vector set engine - assertion macros
// Shared property forms for the checker of the bit vector set engine.
// ----------------------------------------------------------------------------
`ifndef BIT_VECTOR_SET_ENGINE_CORE_ASSERT_SVH
`define BIT_VECTOR_SET_ENGINE_CORE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define BVS_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bit vector set engine: check failed");

// The consequent must hold in the same cycle as the antecedent.
`define BVS_ASSERT_NOW(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bit vector set engine: check failed");

`endif

// File: design/bvs_pkg.sv
// ----------------------------------------------------------------------------
// Bit vector set engine - package
// Sizes, operation and status codes, and the structs shared between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bvs_pkg;

    localparam int MAX_WORDS   = 8;
    localparam int WORD_W      = 32;
    localparam int ADDR_W      = $clog2(MAX_WORDS);
    localparam int WCNT_W      = $clog2(MAX_WORDS + 1);
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int NUM_W       = 9;
    localparam int CNT_W       = 9;
    localparam int KIND_W      = 4;
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int CAP_BITS    = MAX_WORDS * WORD_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_TEST        = 4'd0,
        KIND_SET         = 4'd1,
        KIND_CLEAR       = 4'd2,
        KIND_CLEAR_ALL   = 4'd3,
        KIND_SET_INITIAL = 4'd4,
        KIND_ITER_START  = 4'd5,
        KIND_ITER_NEXT   = 4'd6,
        KIND_COUNT       = 4'd7,
        KIND_REINIT      = 4'd8
    } kind_t;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_GROW  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_CAPACITY = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_WORDS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPANDABLE    = 1'b1;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CAP_BITS);

    typedef struct packed {
        logic                  rd_en;
        logic [ADDR_W-1:0]     rd_addr;
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [WORD_W-1:0]     wr_data;
        logic [MAX_WORDS-1:0]  clr_mask;
    } ram_req_t;

    // Packed so that bit_value lands in the lowest bit of the stream word.
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [CNT_W-1:0]      set_count;
        logic signed [NUM_W-1:0] position;
        logic                  bit_value;
    } result_t;

endpackage

`default_nettype wire

// File: design/bvs_word_ram.sv
// ----------------------------------------------------------------------------
// Bit vector set engine - word store
// Synchronous word memory with a registered read port and a valid bit per
// word; a word whose valid bit is clear reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module bvs_word_ram (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire bvs_pkg::ram_req_t          req,
    output logic [bvs_pkg::WORD_W-1:0]      rd_data
);
    import bvs_pkg::*;

    logic [WORD_W-1:0]    word_mem [MAX_WORDS];
    logic [WORD_W-1:0]    rd_word_reg;
    logic                 rd_valid_reg;
    logic [MAX_WORDS-1:0] valid_reg;
    logic [MAX_WORDS-1:0] valid_next;
    logic [MAX_WORDS-1:0] wr_onehot;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            word_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_word_reg <= word_mem[req.rd_addr];
        end
    end

    // A write in the same cycle as a clear of the same word leaves it valid.
    always_comb
    begin
        wr_onehot = '0;
        if (req.wr_en)
        begin
            wr_onehot[req.wr_addr] = 1'b1;
        end
        valid_next = (valid_reg & ~req.clr_mask) | wr_onehot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

`default_nettype wire

// File: design/bvs_seq.sv
// ----------------------------------------------------------------------------
// Bit vector set engine - operation sequencer
// Runs one operation at a time against the word store: read-modify-write for
// single bits, valid-bit clears for clear_all and re-init, a write sweep for
// set_initial and a one-word-per-cycle scan for count and find-next.
// ----------------------------------------------------------------------------
`default_nettype none

module bvs_seq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [bvs_pkg::KIND_W-1:0]    kind,
    input  wire logic [bvs_pkg::NUM_W-1:0]     number,
    input  wire logic [bvs_pkg::CFG_W-1:0]     initial_words,
    input  wire logic                          expandable,
    output logic                               idle,
    output logic                               res_valid,
    input  wire logic                          res_take,
    output bvs_pkg::result_t                   res,
    output bvs_pkg::ram_req_t                  ram_req,
    input  wire logic [bvs_pkg::WORD_W-1:0]    rd_data
);
    import bvs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_SCAN,
        ST_RESP
    } state_t;

    state_t              state_reg;
    kind_t               kind_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [WCNT_W-1:0]   active_reg;
    logic [NUM_W-1:0]    iter_pos_reg;
    logic [WCNT_W-1:0]   lim_words_reg;
    logic [WCNT_W-1:0]   cur_w_reg;
    logic [ADDR_W-1:0]   fill_reg;
    result_t             res_reg;

    logic [NUM_W-1:0]    live_bits;
    logic [NUM_W-1:0]    lim_bits;
    logic [ADDR_W-1:0]   word_idx;
    logic [BIT_W-1:0]    bit_sel;
    logic [WORD_W-1:0]   bit_mask;
    logic                in_range;
    logic                cap_ok;
    logic [WCNT_W-1:0]   grow_words;
    logic [MAX_WORDS-1:0] grow_clr;
    logic [MAX_WORDS-1:0] active_clr;
    logic [NUM_W:0]      need_sum;
    logic [NUM_W-BIT_W:0] need_words;
    logic                too_long;
    logic                fill_go;
    logic [WCNT_W-1:0]   full_words;
    logic [WORD_W-1:0]   fill_data;
    logic                fill_last;
    logic [WCNT_W-1:0]   clamp_words;
    logic [WCNT_W-1:0]   cur_next;
    logic [WORD_W-1:0]   masked;
    logic [WORD_W-1:0]   onehot;
    logic                hit;
    logic [BIT_W-1:0]    hit_bit;
    logic [NUM_W-1:0]    hit_pos;
    logic                past_end;
    logic                last_word;
    logic                count_last;
    logic [CNT_W-1:0]    word_pop;
    logic [NUM_W-1:0]    miss_pos;

    // Address and range arithmetic for the current operation.
    always_comb
    begin
        live_bits  = NUM_W'(active_reg) << BIT_W;
        lim_bits   = NUM_W'(lim_words_reg) << BIT_W;
        word_idx   = num_reg[BIT_W +: ADDR_W];
        bit_sel    = num_reg[BIT_W-1:0];
        bit_mask   = WORD_W'(1) << bit_sel;
        in_range   = num_reg < live_bits;
        cap_ok     = {1'b0, num_reg} < (NUM_W+1)'(CAP_BITS);
        grow_words = WCNT_W'(num_reg[NUM_W-1:BIT_W]) + WCNT_W'(1);
        need_sum   = {1'b0, num_reg} + (NUM_W+1)'(WORD_W - 1);
        need_words = need_sum[NUM_W:BIT_W];
        too_long   = need_words > (NUM_W-BIT_W+1)'(active_reg);
        fill_go    = (kind_reg == KIND_SET_INITIAL) && !too_long && (need_words != '0);
        full_words = WCNT_W'(num_reg[NUM_W-1:BIT_W]);
        fill_data  = (WCNT_W'(fill_reg) < full_words) ? '1 : (bit_mask - WORD_W'(1));
        fill_last  = (WCNT_W'(fill_reg) + WCNT_W'(1)) == WCNT_W'(need_words);

        if (initial_words == '0)
        begin
            clamp_words = WCNT_W'(1);
        end
        else if (WCNT_W'(initial_words) > WCNT_W'(MAX_WORDS))
        begin
            clamp_words = WCNT_W'(MAX_WORDS);
        end
        else
        begin
            clamp_words = WCNT_W'(initial_words);
        end

        for (int i = 0; i < MAX_WORDS; i++)
        begin
            grow_clr[i]   = (WCNT_W'(i) >= active_reg) && (WCNT_W'(i) < grow_words);
            active_clr[i] = WCNT_W'(i) < active_reg;
        end
    end

    // Scan datapath: one word of the store per cycle.
    always_comb
    begin
        cur_next = cur_w_reg + WCNT_W'(1);
        if (cur_w_reg == iter_pos_reg[NUM_W-1:BIT_W])
        begin
            masked = rd_data & ({WORD_W{1'b1}} << iter_pos_reg[BIT_W-1:0]);
        end
        else
        begin
            masked = rd_data;
        end
        hit    = |masked;
        onehot = masked & (~masked + WORD_W'(1));
        for (int b = 0; b < BIT_W; b++)
        begin
            hit_bit[b] = 1'b0;
            for (int i = 0; i < WORD_W; i++)
            begin
                if (((i >> b) & 1) == 1)
                begin
                    hit_bit[b] = hit_bit[b] | onehot[i];
                end
            end
        end
        hit_pos    = NUM_W'({cur_w_reg[ADDR_W-1:0], hit_bit});
        past_end   = cur_w_reg >= lim_words_reg;
        last_word  = cur_next >= lim_words_reg;
        count_last = cur_next >= active_reg;
        word_pop   = CNT_W'($countones(rd_data));
        miss_pos   = (iter_pos_reg < lim_bits) ? lim_bits : iter_pos_reg;
    end

    // Requests to the word store.
    always_comb
    begin
        ram_req = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ram_req.rd_en = start;
                if (kind == KIND_COUNT)
                begin
                    ram_req.rd_addr = '0;
                end
                else if (kind == KIND_ITER_NEXT)
                begin
                    ram_req.rd_addr = iter_pos_reg[BIT_W +: ADDR_W];
                end
                else
                begin
                    ram_req.rd_addr = number[BIT_W +: ADDR_W];
                end
            end
            ST_EXEC:
            begin
                ram_req.wr_addr = word_idx;
                unique case (kind_reg)
                    KIND_SET:
                    begin
                        if (in_range)
                        begin
                            ram_req.wr_en   = 1'b1;
                            ram_req.wr_data = rd_data | bit_mask;
                        end
                        else if (expandable && cap_ok)
                        begin
                            // Newly added words start from zero, this one included.
                            ram_req.wr_en    = 1'b1;
                            ram_req.wr_data  = bit_mask;
                            ram_req.clr_mask = grow_clr;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        ram_req.wr_en   = in_range;
                        ram_req.wr_data = rd_data & ~bit_mask;
                    end
                    KIND_CLEAR_ALL:
                    begin
                        ram_req.clr_mask = active_clr;
                    end
                    KIND_REINIT:
                    begin
                        ram_req.clr_mask = '1;
                    end
                    default:
                    begin
                        ram_req.wr_en = 1'b0;
                    end
                endcase
            end
            ST_FILL:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = fill_reg;
                ram_req.wr_data = fill_data;
            end
            ST_SCAN:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = cur_next[ADDR_W-1:0];
            end
            ST_RESP:
            begin
                ram_req.rd_en = 1'b0;
            end
            default:
            begin
                ram_req.rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_TEST;
            num_reg       <= '0;
            active_reg    <= WCNT_W'(MAX_WORDS);
            iter_pos_reg  <= '0;
            lim_words_reg <= '0;
            cur_w_reg     <= '0;
            fill_reg      <= '0;
            res_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg <= kind_t'(kind);
                        num_reg  <= number;
                        res_reg  <= '0;
                        if (kind == KIND_COUNT)
                        begin
                            cur_w_reg <= '0;
                            state_reg <= ST_SCAN;
                        end
                        else if (kind == KIND_ITER_NEXT)
                        begin
                            cur_w_reg <= iter_pos_reg[NUM_W-1:BIT_W];
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_EXEC;
                        end
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= fill_go ? ST_FILL : ST_RESP;
                    unique case (kind_reg)
                        KIND_TEST:
                        begin
                            if (in_range)
                            begin
                                res_reg.bit_value <= rd_data[bit_sel];
                            end
                            else
                            begin
                                res_reg.status <= STATUS_RANGE;
                            end
                        end
                        KIND_SET:
                        begin
                            if (!in_range)
                            begin
                                if (!expandable)
                                begin
                                    res_reg.status <= STATUS_NO_GROW;
                                end
                                else if (!cap_ok)
                                begin
                                    res_reg.status <= STATUS_CAPACITY;
                                end
                                else
                                begin
                                    active_reg <= grow_words;
                                end
                            end
                        end
                        KIND_CLEAR:
                        begin
                            if (!in_range)
                            begin
                                res_reg.status <= STATUS_RANGE;
                            end
                        end
                        KIND_SET_INITIAL:
                        begin
                            if (too_long)
                            begin
                                res_reg.status <= STATUS_RANGE;
                            end
                            else if (need_words != '0)
                            begin
                                fill_reg <= '0;
                            end
                        end
                        KIND_ITER_START:
                        begin
                            iter_pos_reg  <= '0;
                            lim_words_reg <= active_reg;
                        end
                        KIND_REINIT:
                        begin
                            active_reg    <= clamp_words;
                            iter_pos_reg  <= '0;
                            lim_words_reg <= '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_FILL:
                begin
                    fill_reg <= fill_reg + ADDR_W'(1);
                    if (fill_last)
                    begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_SCAN:
                begin
                    cur_w_reg <= cur_next;
                    if (kind_reg == KIND_COUNT)
                    begin
                        res_reg.set_count <= res_reg.set_count + word_pop;
                        if (count_last)
                        begin
                            state_reg <= ST_RESP;
                        end
                    end
                    else if (past_end || (!hit && last_word))
                    begin
                        res_reg.position <= '1;
                        iter_pos_reg     <= miss_pos;
                        state_reg        <= ST_RESP;
                    end
                    else if (hit)
                    begin
                        res_reg.position <= hit_pos;
                        iter_pos_reg     <= hit_pos + NUM_W'(1);
                        state_reg        <= ST_RESP;
                    end
                end
                ST_RESP:
                begin
                    if (res_take)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign idle      = state_reg == ST_IDLE;
    assign res_valid = state_reg == ST_RESP;
    assign res       = res_reg;

endmodule

`default_nettype wire

// File: design/bit_vector_set_engine_core.sv
// ----------------------------------------------------------------------------
// Bit vector set engine - top level
// Bit set of up to eight 32-bit words with an active size, driven by one
// operation per input transfer and answering with one result transfer.
//
//   channel   direction  payload
//   s_axis    in         tuser: kind; tdata: number
//   m_axis    out        tdata: bit_value, position, set_count, status
//   cfg       in         cfg_index 0 initial_words, 1 expandable
//
// Test, set, clear, clear_all, iter_start, re-init and unknown kinds pass an
// execute and a response state; set_initial adds a fill state writing the words
// in turn; count and iter_next scan the store word by word through its single
// read port. Reset clears the per-word valid bits at once, so the store needs
// no clearing pass. A stalled result sits in the output register while the
// next transfer is accepted and worked on.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_vector_set_engine_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // number[8:0], zeros above
    input  wire logic [bvs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // kind[3:0]
    input  wire logic [bvs_pkg::KIND_W-1:0]         s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // bit_value[0], position[9:1], set_count[18:10], status[20:19], zeros above
    output logic [bvs_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    input  wire logic                               cfg_we,
    input  wire logic [bvs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bvs_pkg::CFG_W-1:0]          cfg_data
);
    import bvs_pkg::*;

    logic [CFG_W-1:0] initial_words_reg;
    logic             expandable_reg;
    logic             m_valid_reg;
    result_t          m_data_reg;

    logic             seq_idle;
    logic             res_valid;
    logic             slot_free;
    result_t          res;
    ram_req_t         ram_req;
    logic [WORD_W-1:0] rd_data;

    assign s_axis_tready = seq_idle;
    assign slot_free     = !m_valid_reg || m_axis_tready;

    bvs_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (s_axis_tvalid && seq_idle),
        .kind          (s_axis_tuser),
        .number        (s_axis_tdata[NUM_W-1:0]),
        .initial_words (initial_words_reg),
        .expandable    (expandable_reg),
        .idle          (seq_idle),
        .res_valid     (res_valid),
        .res_take      (slot_free),
        .res           (res),
        .ram_req       (ram_req),
        .rd_data       (rd_data)
    );

    bvs_word_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_words_reg <= CFG_W'(MAX_WORDS);
            expandable_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INITIAL_WORDS: initial_words_reg <= cfg_data;
                CFG_EXPANDABLE:    expandable_reg    <= cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end
        else if (res_valid && slot_free)
        begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= res;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(m_data_reg);

endmodule

`default_nettype wire

// File: design/bvs_core_chk.sv
// ----------------------------------------------------------------------------
// Bit vector set engine - port checker
// Watches the top-level ports for ordering and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bit_vector_set_engine_core_assert.svh"

module bvs_core_chk (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    input  wire logic                               s_axis_tready,
    input  wire logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic [bvs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import bvs_pkg::*;

    // A stalled result must not change under the consumer.
    `BVS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // Only one operation is in flight: the transfer after an accept waits.
    `BVS_ASSERT_NEXT(a_single_op, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // An error result carries no other information.
    `BVS_ASSERT_NOW(a_err_clean, m_axis_tvalid && (m_axis_tdata[20:19] != STATUS_OK), m_axis_tdata[18:0] == 19'd0)

    // A find-next answer comes alone and never with an error.
    `BVS_ASSERT_NOW(a_pos_alone, m_axis_tvalid && (m_axis_tdata[9:1] != 9'd0), (m_axis_tdata[0] == 1'b0) && (m_axis_tdata[18:10] == 9'd0) && (m_axis_tdata[20:19] == STATUS_OK))

    // The count can never exceed the capacity of the store.
    `BVS_ASSERT_NOW(a_count_bound, m_axis_tvalid, m_axis_tdata[18:10] <= CNT_MAX)

endmodule

bind bit_vector_set_engine_core bvs_core_chk u_chk (.*);

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit vector set engine - self-checking testbench
// Drives a short table of directed operations and then random operation
// streams under several register settings. Every result transfer is compared
// field by field with the expected value of its table row or with the output
// of a behavioural model of the bit set held in this file. Both stream sides
// idle at random, with long receiver hold-offs.
// ----------------------------------------------------------------------------

module testbench;

    import bvs_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DIRECTED_N   = 25;

    localparam logic [KIND_W-1:0] KIND_FIRST_UNUSED = 4'd9;
    localparam logic [KIND_W-1:0] KIND_LAST_UNUSED  = 4'd15;
    localparam logic [NUM_W-1:0]  NO_HIT            = '1;

    typedef struct {
        bit                  reconfig;
        logic [CFG_W-1:0]    words;
        bit                  grow;
        logic [KIND_W-1:0]   kind;
        logic [NUM_W-1:0]    num;
        bit                  typed;
        logic                bitv;
        logic [NUM_W-1:0]    pos;
        logic [CNT_W-1:0]    cnt;
        logic [STATUS_W-1:0] status;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [KIND_W-1:0]      s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    // Model of the bit set and its registers.
    logic [WORD_W-1:0] model_words [MAX_WORDS];
    int unsigned       model_active;
    int unsigned       scan_pos;
    int unsigned       scan_limit;
    logic [CFG_W-1:0]  model_init_words;
    bit                model_grow;

    result_t pending_results [$];

    int  items_sent;
    int  results_checked;
    int  failures;
    int  iter_hits;
    int  error_results;
    int  settings_used;
    int  burst_left;
    bit  hold_req;

    plan_row_t directed_plan [DIRECTED_N] = '{
        '{0, 0, 0, KIND_COUNT,        9'd0,   1, 0, 0,      0,   STATUS_OK},
        '{0, 0, 0, KIND_TEST,         9'd256, 1, 0, 0,      0,   STATUS_RANGE},
        '{0, 0, 0, KIND_ITER_NEXT,    9'd0,   1, 0, NO_HIT, 0,   STATUS_OK},
        '{0, 0, 0, KIND_SET,          9'd0,   1, 0, 0,      0,   STATUS_OK},
        '{0, 0, 0, KIND_SET,          9'd255, 1, 0, 0,      0,   STATUS_OK},
        '{0, 0, 0, KIND_SET,          9'd511, 1, 0, 0,      0,   STATUS_CAPACITY},
        '{0, 0, 0, KIND_TEST,         9'd255, 1, 1, 0,      0,   STATUS_OK},
        '{0, 0, 0, KIND_ITER_START,   9'd0,   1, 0, 0,      0,   STATUS_OK},
        '{0, 0, 0, KIND_ITER_NEXT,    9'd0,   1, 0, 9'd0,   0,   STATUS_OK},
        '{0, 0, 0, KIND_ITER_NEXT,    9'd0,   1, 0, 9'd255, 0,   STATUS_OK},
        '{0, 0, 0, KIND_ITER_NEXT,    9'd0,   1, 0, NO_HIT, 0,   STATUS_OK},
        '{0, 0, 0, KIND_CLEAR,        9'd255, 1, 0, 0,      0,   STATUS_OK},
        '{0, 0, 0, KIND_CLEAR,        9'd256, 1, 0, 0,      0,   STATUS_RANGE},
        '{0, 0, 0, KIND_SET_INITIAL,  9'd257, 1, 0, 0,      0,   STATUS_RANGE},
        '{0, 0, 0, KIND_SET_INITIAL,  9'd256, 1, 0, 0,      0,   STATUS_OK},
        '{0, 0, 0, KIND_COUNT,        9'd0,   1, 0, 0,      256, STATUS_OK},
        '{0, 0, 0, KIND_SET_INITIAL,  9'd37,  0, 0, 0,      0,   STATUS_OK},
        '{0, 0, 0, KIND_CLEAR_ALL,    9'd0,   0, 0, 0,      0,   STATUS_OK},
        '{0, 0, 0, KIND_LAST_UNUSED,  9'd511, 1, 0, 0,      0,   STATUS_OK},
        '{1, 1, 0, KIND_REINIT,       9'd0,   1, 0, 0,      0,   STATUS_OK},
        '{0, 0, 0, KIND_SET,          9'd32,  1, 0, 0,      0,   STATUS_NO_GROW},
        '{1, 0, 1, KIND_REINIT,       9'd0,   1, 0, 0,      0,   STATUS_OK},
        '{0, 0, 0, KIND_SET,          9'd100, 0, 0, 0,      0,   STATUS_OK},
        '{1, 15, 1, KIND_REINIT,      9'd0,   0, 0, 0,      0,   STATUS_OK},
        '{0, 0, 0, KIND_TEST,         9'd255, 0, 0, 0,      0,   STATUS_OK}
    };

    bit_vector_set_engine_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("%0t: run timed out with %0d results outstanding", $time,
                 pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic model_bit(input int unsigned idx);
        return model_words[(idx >> BIT_W) % MAX_WORDS][idx % WORD_W];
    endfunction

    function automatic void reset_model();
        foreach (model_words[i])
            model_words[i] = '0;
        model_init_words = CFG_W'(MAX_WORDS);
        model_grow       = 1'b1;
        model_active     = MAX_WORDS;
        scan_pos         = 0;
        scan_limit       = 0;
    endfunction

    // Applies one operation to the model and returns the result it answers.
    function automatic result_t apply_op(input logic [KIND_W-1:0] kind,
                                         input logic [NUM_W-1:0] num);
        result_t     r;
        int unsigned live_bits;
        int unsigned grown;
        int unsigned lim;
        int unsigned hit_at;
        int unsigned word_idx;
        bit          hit;
        r         = '0;
        live_bits = model_active * WORD_W;
        word_idx  = (num >> BIT_W) % MAX_WORDS;
        hit       = 1'b0;
        hit_at    = 0;
        case (kind)
            KIND_TEST:
            begin
                if (num >= live_bits)
                    r.status = STATUS_RANGE;
                else
                    r.bit_value = model_bit(num);
            end
            KIND_SET:
            begin
                if (num >= live_bits && !model_grow)
                    r.status = STATUS_NO_GROW;
                else if (num >= live_bits && num >= CAP_BITS)
                    r.status = STATUS_CAPACITY;
                else
                begin
                    // Growth clears the words it brings into the live vector.
                    if (num >= live_bits)
                    begin
                        grown = (num + WORD_W) >> BIT_W;
                        for (int unsigned i = model_active; i < grown; i++)
                            model_words[i] = '0;
                        model_active = grown;
                    end
                    model_words[word_idx][num[BIT_W-1:0]] = 1'b1;
                end
            end
            KIND_CLEAR:
            begin
                if (num >= live_bits)
                    r.status = STATUS_RANGE;
                else
                    model_words[word_idx][num[BIT_W-1:0]] = 1'b0;
            end
            KIND_CLEAR_ALL:
            begin
                for (int unsigned i = 0; i < model_active; i++)
                    model_words[i] = '0;
            end
            KIND_SET_INITIAL:
            begin
                if (((num + WORD_W - 1) >> BIT_W) > model_active)
                    r.status = STATUS_RANGE;
                else
                begin
                    for (int unsigned i = 0; i < (num >> BIT_W); i++)
                        model_words[i] = '1;
                    if (num[BIT_W-1:0] != '0)
                        model_words[word_idx] = (WORD_W'(1) << num[BIT_W-1:0]) - 1;
                end
            end
            KIND_ITER_START:
            begin
                scan_pos   = 0;
                scan_limit = live_bits;
            end
            KIND_ITER_NEXT:
            begin
                lim = (scan_limit < CAP_BITS) ? scan_limit : CAP_BITS;
                for (int unsigned i = scan_pos; i < lim && !hit; i++)
                begin
                    if (model_bit(i))
                    begin
                        hit    = 1'b1;
                        hit_at = i;
                    end
                end
                if (hit)
                begin
                    r.position = NUM_W'(hit_at);
                    scan_pos   = hit_at + 1;
                    iter_hits++;
                end
                else
                begin
                    r.position = NO_HIT;
                    if (scan_pos < scan_limit)
                        scan_pos = scan_limit;
                end
            end
            KIND_COUNT:
            begin
                for (int unsigned i = 0; i < model_active; i++)
                    r.set_count += CNT_W'($countones(model_words[i]));
            end
            KIND_REINIT:
            begin
                foreach (model_words[i])
                    model_words[i] = '0;
                if (model_init_words == '0)
                    model_active = 1;
                else if (model_init_words > MAX_WORDS)
                    model_active = MAX_WORDS;
                else
                    model_active = model_init_words;
                scan_pos   = 0;
                scan_limit = 0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t seen;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
            if (pending_results.size() == 0)
            begin
                $display("%0t: result %h arrived with none expected, expected nothing, got %h",
                         $time, m_axis_tdata, m_axis_tdata);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                check_field("bit_value", want.bit_value, seen.bit_value);
                check_field("position", $unsigned(want.position), $unsigned(seen.position));
                check_field("set_count", want.set_count, seen.set_count);
                check_field("status", want.status, seen.status);
                check_field("tdata padding", 0, m_axis_tdata[OUT_TDATA_W-1:$bits(result_t)]);
            end
        end
    end

    // Receiver: stall patterns change at random intervals; a hold request keeps
    // tready low for a long stretch so that the engine backs up.
    initial
    begin : result_sink
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(8, 80);
                end
                mode_left--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offers one operation and waits for its transfer. Bursts of back-to-back
    // transfers are separated by idle gaps of random length.
    task automatic offer(input logic [KIND_W-1:0] kind, input logic [NUM_W-1:0] num,
                         input bit typed, input result_t typed_want);
        int      gap;
        result_t predicted;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 60);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(num);
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = apply_op(kind, num);
        if (predicted.status != STATUS_OK)
            error_results++;
        pending_results.push_back(typed ? typed_want : predicted);
        items_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_settings(input logic [CFG_W-1:0] words, input bit grow);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INITIAL_WORDS;
        cfg_data  <= words;
        @(posedge clk);
        cfg_index <= CFG_EXPANDABLE;
        cfg_data  <= CFG_W'(grow);
        @(posedge clk);
        cfg_we <= 1'b0;
        model_init_words = words;
        model_grow       = grow;
        settings_used++;
    endtask

    // Bit index mostly inside the live vector, sometimes at its edge or anywhere.
    function automatic logic [NUM_W-1:0] pick_index();
        int unsigned live_bits;
        int unsigned r;
        live_bits = model_active * WORD_W;
        r         = $urandom_range(0, 9);
        if (r < 7)
            return NUM_W'($urandom_range(0, live_bits - 1));
        else if (r < 8)
            return NUM_W'($urandom_range(live_bits - 1, live_bits + 1));
        else
            return NUM_W'($urandom_range(0, (1 << NUM_W) - 1));
    endfunction

    initial
    begin : stimulus
        result_t             want;
        logic [CFG_W-1:0]    words;
        logic [NUM_W-1:0]    num;
        int                  pick;
        int                  run_len;
        int                  phase;
        int                  phase_end;
        rst_n         = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        hold_req      = 1'b0;
        burst_left    = 0;
        reset_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].reconfig)
            begin
                drain();
                write_settings(directed_plan[i].words, directed_plan[i].grow);
            end
            want           = '0;
            want.bit_value = directed_plan[i].bitv;
            want.position  = directed_plan[i].pos;
            want.set_count = directed_plan[i].cnt;
            want.status    = directed_plan[i].status;
            offer(directed_plan[i].kind, directed_plan[i].num, directed_plan[i].typed, want);
        end

        phase = 0;
        while (items_sent < DIRECTED_N + RANDOM_ITEMS)
        begin
            // Every phase starts from an idle engine, so the sender pauses here
            // until every expected result has come back.
            drain();
            case ($urandom_range(0, 5))
                0:       words = '0;
                1:       words = CFG_W'(1);
                2:       words = CFG_W'(MAX_WORDS);
                3:       words = '1;
                default: words = CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
            endcase
            write_settings(words, 1'($urandom_range(0, 1)));
            if (phase == 2 || phase == 7)
                hold_req = 1'b1;
            if ($urandom_range(0, 2) != 0)
                offer(KIND_REINIT, NUM_W'($urandom), 1'b0, want);
            phase_end = items_sent + $urandom_range(100, 200);
            while (items_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                num  = NUM_W'($urandom);
                if (pick < 30)
                begin
                    // An iteration walk: a start and then a random number of steps.
                    offer(KIND_ITER_START, num, 1'b0, want);
                    run_len = $urandom_range(1, 12);
                    repeat (run_len)
                        offer(KIND_ITER_NEXT, NUM_W'($urandom), 1'b0, want);
                end
                else if (pick < 50)
                    offer(KIND_SET, pick_index(), 1'b0, want);
                else if (pick < 63)
                    offer(KIND_TEST, pick_index(), 1'b0, want);
                else if (pick < 73)
                    offer(KIND_CLEAR, pick_index(), 1'b0, want);
                else if (pick < 79)
                    offer(KIND_COUNT, num, 1'b0, want);
                else if (pick < 85)
                begin
                    if ($urandom_range(0, 3) != 0)
                        num = NUM_W'($urandom_range(0, model_active * WORD_W));
                    offer(KIND_SET_INITIAL, num, 1'b0, want);
                end
                else if (pick < 88)
                    offer(KIND_CLEAR_ALL, num, 1'b0, want);
                else if (pick < 90)
                    offer(KIND_REINIT, num, 1'b0, want);
                else if (pick < 96)
                    offer(KIND_ITER_NEXT, num, 1'b0, want);
                else
                    offer(KIND_W'($urandom_range(KIND_FIRST_UNUSED, KIND_LAST_UNUSED)),
                          num, 1'b0, want);
            end
            phase++;
        end

        drain();
        repeat (20) @(posedge clk);

        $display("Covered %0d operations (%0d from the directed table) over %0d register settings.",
                 items_sent, DIRECTED_N, settings_used);
        $display("Compared %0d results: %0d iteration hits, %0d error statuses, %0d failures.",
                 results_checked, iter_hits, error_results, failures);
        if (failures == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
